// ----- rtl/mcom_pkg.sv -----
package mcom_pkg;

  localparam int NumMotors  = 4;
  localparam int AlphaW     = 9;
  localparam int StepW      = 8;
  localparam int AlphaShift = 8;

  localparam logic [AlphaW-1:0] AlphaOne = AlphaW'(256);

  localparam logic [AlphaW-1:0] AlphaRst  = AlphaW'(205);
  localparam int                TripRst   = 800;
  localparam logic [StepW-1:0]  MinStpRst = StepW'(10);
  localparam logic [StepW-1:0]  ConsecRst = StepW'(1);

  typedef enum logic [1:0] {
    CFG_ALPHA  = 2'd0,
    CFG_TRIP   = 2'd1,
    CFG_MINSTP = 2'd2,
    CFG_CONSEC = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic en;
    logic first;
  } lane_ctrl_t;

endpackage

// ----- rtl/motor_current_overload_monitor_core.sv -----
// Channel  | Handshake                      | Payload
// input    | in_valid_i / in_ready_o        | current_0..3_i, drive_active_i, gear_is_high_i
// result   | out_valid_o / out_ready_i      | downshift_o, average_0..3_o, above_count_0..3_o
// config   | cfg_we_i (no wait)             | cfg_idx_i, cfg_wdata_i
//
// One request per cycle sustained while out_ready_i is high.
// A request sits in the input register, then one pass through the four lanes (one
// 9x20 multiply pair each) loads the averages, counters and the result register.
// Reset clears averages, counters, step count and valids, and loads config defaults.
// A stalled result holds the pipe; the input register still takes one more request.
module motor_current_overload_monitor_core
  import mcom_pkg::*;
#(
  parameter int CURRENT_BITS = 12,
  parameter int FRAC_BITS    = 8,
  parameter int COUNT_BITS   = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [((CURRENT_BITS > AlphaW) ? CURRENT_BITS : AlphaW)-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [CURRENT_BITS-1:0] current_0_i,
  input  logic [CURRENT_BITS-1:0] current_1_i,
  input  logic [CURRENT_BITS-1:0] current_2_i,
  input  logic [CURRENT_BITS-1:0] current_3_i,
  input  logic                    drive_active_i,
  input  logic                    gear_is_high_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    downshift_o,
  output logic [CURRENT_BITS-1:0] average_0_o,
  output logic [CURRENT_BITS-1:0] average_1_o,
  output logic [CURRENT_BITS-1:0] average_2_o,
  output logic [CURRENT_BITS-1:0] average_3_o,
  output logic [COUNT_BITS-1:0]   above_count_0_o,
  output logic [COUNT_BITS-1:0]   above_count_1_o,
  output logic [COUNT_BITS-1:0]   above_count_2_o,
  output logic [COUNT_BITS-1:0]   above_count_3_o
);

  localparam int CmpW = (COUNT_BITS > StepW) ? COUNT_BITS : StepW;

  // config
  logic [AlphaW-1:0]       alpha_q;
  logic [CURRENT_BITS-1:0] trip_q;
  logic [StepW-1:0]        min_steps_q;
  logic [StepW-1:0]        consec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q     <= AlphaRst;
      trip_q      <= CURRENT_BITS'(TripRst);
      min_steps_q <= MinStpRst;
      consec_q    <= ConsecRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ALPHA:  alpha_q     <= cfg_wdata_i[AlphaW-1:0];
        CFG_TRIP:   trip_q      <= cfg_wdata_i[CURRENT_BITS-1:0];
        CFG_MINSTP: min_steps_q <= cfg_wdata_i[StepW-1:0];
        CFG_CONSEC: consec_q    <= cfg_wdata_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  logic [AlphaW-1:0] alpha_sat;
  assign alpha_sat = (alpha_q > AlphaOne) ? AlphaOne : alpha_q;

  // input register
  logic                    in_vld_q;
  logic [CURRENT_BITS-1:0] cur_q [NumMotors];
  logic                    drive_q, gear_q;
  logic                    advance, fire;

  assign advance    = !out_valid_o || out_ready_i;
  assign fire       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cur_q[0] <= current_0_i;
      cur_q[1] <= current_1_i;
      cur_q[2] <= current_2_i;
      cur_q[3] <= current_3_i;
      drive_q  <= drive_active_i;
      gear_q   <= gear_is_high_i;
    end
  end

  // step count
  logic [COUNT_BITS-1:0] steps_q, steps_d;
  logic                  steps_ok;

  assign steps_d  = (&steps_q) ? steps_q : steps_q + COUNT_BITS'(1);
  assign steps_ok = (CmpW'(steps_d) >= CmpW'(min_steps_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
    end else if (fire) begin
      steps_q <= steps_d;
    end
  end

  lane_ctrl_t lane_ctrl;
  assign lane_ctrl.en    = fire;
  assign lane_ctrl.first = (steps_q == '0);

  logic [CURRENT_BITS-1:0] avg [NumMotors];
  logic [COUNT_BITS-1:0]   cnt [NumMotors];
  logic [NumMotors-1:0]    hit;

  for (genvar m = 0; m < NumMotors; m++) begin : g_lane
    mcom_lane #(
      .CURRENT_BITS(CURRENT_BITS),
      .FRAC_BITS   (FRAC_BITS),
      .COUNT_BITS  (COUNT_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .alpha_i (alpha_sat),
      .trip_i  (trip_q),
      .consec_i(consec_q),
      .sample_i(cur_q[m]),
      .avg_o   (avg[m]),
      .cnt_o   (cnt[m]),
      .hit_o   (hit[m])
    );
  end

  // result register
  logic                    out_vld_q;
  logic                    dshift_q;
  logic [CURRENT_BITS-1:0] avg_q [NumMotors];
  logic [COUNT_BITS-1:0]   cnt_q [NumMotors];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      dshift_q <= steps_ok && (|hit) && drive_q && gear_q;
      avg_q    <= avg;
      cnt_q    <= cnt;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign downshift_o     = dshift_q;
  assign average_0_o     = avg_q[0];
  assign average_1_o     = avg_q[1];
  assign average_2_o     = avg_q[2];
  assign average_3_o     = avg_q[3];
  assign above_count_0_o = cnt_q[0];
  assign above_count_1_o = cnt_q[1];
  assign above_count_2_o = cnt_q[2];
  assign above_count_3_o = cnt_q[3];

endmodule

// ----- rtl/mcom_lane.sv -----
module mcom_lane
  import mcom_pkg::*;
#(
  parameter int CURRENT_BITS = 12,
  parameter int FRAC_BITS    = 8,
  parameter int COUNT_BITS   = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_ctrl_t              ctrl_i,
  input  logic [AlphaW-1:0]       alpha_i,
  input  logic [CURRENT_BITS-1:0] trip_i,
  input  logic [StepW-1:0]        consec_i,
  input  logic [CURRENT_BITS-1:0] sample_i,
  output logic [CURRENT_BITS-1:0] avg_o,
  output logic [COUNT_BITS-1:0]   cnt_o,
  output logic                    hit_o
);

  localparam int AvgW  = CURRENT_BITS + FRAC_BITS;
  localparam int ProdW = AvgW + AlphaW;
  localparam int SumW  = ProdW + 1;
  localparam int CmpW  = (COUNT_BITS > StepW) ? COUNT_BITS : StepW;

  logic [AvgW-1:0]       avg_q, avg_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [AvgW-1:0]       s_full;
  logic [ProdW-1:0]      prod_new, prod_old;
  logic [SumW-1:0]       sum;
  logic [AlphaW-1:0]     alpha_inv;
  logic                  above;

  assign s_full    = {sample_i, {FRAC_BITS{1'b0}}};
  assign alpha_inv = AlphaOne - alpha_i;
  assign prod_new  = ProdW'(alpha_i) * ProdW'(s_full);
  assign prod_old  = ProdW'(alpha_inv) * ProdW'(avg_q);
  assign sum       = SumW'(prod_new) + SumW'(prod_old);

  always_comb begin
    if (ctrl_i.first) begin
      avg_d = s_full;
    end else begin
      avg_d = sum[AlphaShift +: AvgW];
    end
  end

  assign above = (avg_d[FRAC_BITS +: CURRENT_BITS] >= trip_i);

  always_comb begin
    if (ctrl_i.first || !above) begin
      cnt_d = '0;
    end else if (&cnt_q) begin
      cnt_d = cnt_q;
    end else begin
      cnt_d = cnt_q + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
      cnt_q <= '0;
    end else if (ctrl_i.en) begin
      avg_q <= avg_d;
      cnt_q <= cnt_d;
    end
  end

  assign avg_o = avg_d[FRAC_BITS +: CURRENT_BITS];
  assign cnt_o = cnt_d;
  assign hit_o = !ctrl_i.first && above && (CmpW'(cnt_d) >= CmpW'(consec_i));

endmodule

// ----- rtl/mcom_checker.sv -----
module mcom_checker #(
  parameter int COUNT_BITS = 8
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  downshift_o,
  input logic [COUNT_BITS-1:0] above_count_0_o,
  input logic [COUNT_BITS-1:0] above_count_1_o,
  input logic [COUNT_BITS-1:0] above_count_2_o,
  input logic [COUNT_BITS-1:0] above_count_3_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result stage");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  a_dshift_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && downshift_o |->
      (above_count_0_o != '0) || (above_count_1_o != '0) ||
      (above_count_2_o != '0) || (above_count_3_o != '0))
    else $error("downshift with no motor above trip");

endmodule

bind motor_current_overload_monitor_core mcom_checker #(
  .COUNT_BITS(COUNT_BITS)
) u_mcom_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .downshift_o    (downshift_o),
  .above_count_0_o(above_count_0_o),
  .above_count_1_o(above_count_1_o),
  .above_count_2_o(above_count_2_o),
  .above_count_3_o(above_count_3_o)
);

// ----- bench/tb_motor_current_overload_monitor_core.sv -----
module tb_motor_current_overload_monitor_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mcom_pkg::*;

  localparam int CurW       = 12;
  localparam int CntW       = 8;
  localparam int EmaW       = CurW + 8;
  localparam int CfgDataW   = 12;
  localparam int CycleLimit = 400000;
  localparam int DrainWait  = 4;
  localparam int TailWait   = 10;

  typedef struct packed {
    logic [NumMotors-1:0][CurW-1:0] current;
    logic                           drive;
    logic                           high_gear;
  } sample_t;

  typedef struct packed {
    logic                           downshift;
    logic [NumMotors-1:0][CurW-1:0] average;
    logic [NumMotors-1:0][CntW-1:0] count;
  } status_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_idx_e            cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CurW-1:0]     current_0_i, current_1_i, current_2_i, current_3_i;
  logic                drive_active_i;
  logic                gear_is_high_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                downshift_o;
  logic [CurW-1:0]     average_0_o, average_1_o, average_2_o, average_3_o;
  logic [CntW-1:0]     above_count_0_o, above_count_1_o, above_count_2_o, above_count_3_o;

  logic [AlphaW-1:0] alpha_q;
  logic [CurW-1:0]   trip_q;
  logic [7:0]        min_steps_q;
  logic [7:0]        consec_q;
  logic [EmaW-1:0]   ema_q [NumMotors];
  logic [CntW-1:0]   run_q [NumMotors];
  logic [7:0]        steps_q;

  status_t status_fifo [$];
  int      n_errors      = 0;
  int      burst_left    = 0;
  bit      no_gaps       = 1'b0;
  int      hold_off_req  = 0;

  motor_current_overload_monitor_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .current_0_i    (current_0_i),
    .current_1_i    (current_1_i),
    .current_2_i    (current_2_i),
    .current_3_i    (current_3_i),
    .drive_active_i (drive_active_i),
    .gear_is_high_i (gear_is_high_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .downshift_o    (downshift_o),
    .average_0_o    (average_0_o),
    .average_1_o    (average_1_o),
    .average_2_o    (average_2_o),
    .average_3_o    (average_3_o),
    .above_count_0_o(above_count_0_o),
    .above_count_1_o(above_count_1_o),
    .above_count_2_o(above_count_2_o),
    .above_count_3_o(above_count_3_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic status_t next_status(sample_t s);
    status_t         r;
    logic [9:0]      w;
    logic [EmaW-1:0] smp;
    logic [EmaW-1:0] trip_fx;
    logic [31:0]     acc;
    logic            first;
    logic            hit;
    w       = (alpha_q > AlphaOne) ? 10'd256 : {1'b0, alpha_q};
    first   = (steps_q == 8'd0);
    hit     = 1'b0;
    trip_fx = {trip_q, 8'h00};
    if (steps_q != 8'hFF) steps_q = steps_q + 8'd1;
    for (int m = 0; m < NumMotors; m++) begin
      smp = {s.current[m], 8'h00};
      if (first) begin
        ema_q[m] = smp;
        run_q[m] = '0;
      end else begin
        acc      = 32'(w) * 32'(smp) + 32'(10'd256 - w) * 32'(ema_q[m]);
        ema_q[m] = acc[EmaW+7:8];
        if (ema_q[m] >= trip_fx) begin
          if (run_q[m] != 8'hFF) run_q[m] = run_q[m] + 8'd1;
        end else begin
          run_q[m] = '0;
        end
        if (steps_q >= min_steps_q && ema_q[m] >= trip_fx && run_q[m] >= consec_q) hit = 1'b1;
      end
      r.average[m] = ema_q[m][EmaW-1:8];
      r.count[m]   = run_q[m];
    end
    r.downshift = hit & s.drive & s.high_gear;
    return r;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    for (int m = 0; m < NumMotors; m++) s.current[m] = CurW'($urandom());
    s.drive     = 1'($urandom());
    s.high_gear = 1'($urandom());
    return s;
  endfunction

  function automatic logic [CurW-1:0] clamp_current(int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return CurW'(v);
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // valid stays high across back-to-back requests; callers follow with another
  // send, a drain or a config write in the same step
  task automatic send_sample(sample_t s);
    logic acc;
    int   gap;
    if (burst_left == 0) begin
      gap        = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    current_0_i    <= s.current[0];
    current_1_i    <= s.current[1];
    current_2_i    <= s.current[2];
    current_3_i    <= s.current[3];
    drive_active_i <= s.drive;
    gear_is_high_i <= s.high_gear;
    acc = 1'b0;
    while (!acc) begin
      @(negedge clk_i);
      acc = in_ready_o;
      if (acc) status_fifo.push_back(next_status(s));
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (status_fifo.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic configure(logic [AlphaW-1:0] a, logic [CurW-1:0] trip, logic [7:0] mins,
                           logic [7:0] cons);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ALPHA;
    cfg_wdata_i <= CfgDataW'(a);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TRIP;
    cfg_wdata_i <= CfgDataW'(trip);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MINSTP;
    cfg_wdata_i <= CfgDataW'(mins);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_CONSEC;
    cfg_wdata_i <= CfgDataW'(cons);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    alpha_q     = a;
    trip_q      = trip;
    min_steps_q = mins;
    consec_q    = cons;
  endtask

  // reset defaults; first request loads raw samples and never trips
  task automatic test_first_sample();
    sample_t s;
    s.current   = {NumMotors{12'hFFF}};
    s.drive     = 1'b1;
    s.high_gear = 1'b1;
    repeat (9) send_sample(s);
    s.drive = 1'b0;
    send_sample(s);
    s.drive     = 1'b1;
    s.high_gear = 1'b0;
    send_sample(s);
    s.high_gear = 1'b1;
    send_sample(s);
    drain();
  endtask

  task automatic test_alpha_extremes();
    sample_t s;
    s.drive     = 1'b1;
    s.high_gear = 1'b1;
    s.current   = '0;
    configure('0, CurW'(TripRst), MinStpRst, ConsecRst);
    send_sample(s);
    drain();
    configure(AlphaOne, CurW'(TripRst), MinStpRst, ConsecRst);
    s.current = {12'h000, 12'hFFF, 12'h555, 12'hAAA};
    send_sample(s);
    drain();
    configure(9'h1FF, CurW'(TripRst), MinStpRst, ConsecRst);
    s.current = {12'hAAA, 12'h555, 12'hFFF, 12'h000};
    send_sample(s);
    drain();
    configure(9'd257, CurW'(TripRst), MinStpRst, ConsecRst);
    s.current = '0;
    send_sample(s);
    drain();
    configure(9'd1, CurW'(TripRst), MinStpRst, ConsecRst);
    s.current = '1;
    send_sample(s);
    drain();
  endtask

  task automatic test_thresholds();
    sample_t s;
    s.current   = '0;
    s.drive     = 1'b1;
    s.high_gear = 1'b1;
    configure(AlphaOne, '0, 8'd0, 8'd0);
    send_sample(s);
    s.drive = 1'b0;
    send_sample(s);
    drain();
    configure(AlphaOne, 12'hFFF, 8'hFF, 8'hFF);
    s.drive   = 1'b1;
    s.current = '1;
    send_sample(s);
    send_sample(s);
    drain();
    configure(AlphaOne, 12'hFFF, 8'd0, 8'd1);
    s.current = {12'h000, 12'h000, 12'h000, 12'hFFF};
    send_sample(s);
    s.current = {12'hFFE, 12'h000, 12'h000, 12'h000};
    send_sample(s);
    drain();
  endtask

  // above counters run into saturation with the trip level at zero
  task automatic test_count_saturation();
    configure(AlphaOne, '0, 8'd0, 8'hFF);
    repeat (300) send_sample(random_sample());
    drain();
  endtask

  task automatic test_backpressure();
    configure(9'd128, 12'd1000, 8'd0, 8'd2);
    no_gaps      = 1'b1;
    hold_off_req = 300;
    repeat (40) send_sample(random_sample());
    no_gaps = 1'b0;
    drain();
  endtask

  // currents wander around the trip level so averages cross it in both directions
  task automatic test_random_phases();
    sample_t           s;
    logic [AlphaW-1:0] a;
    logic [CurW-1:0]   trip;
    logic [7:0]        mins;
    logic [7:0]        cons;
    logic [CurW-1:0]   base [NumMotors];
    repeat (9) begin
      case ($urandom_range(0, 5))
        0:       a = '0;
        1:       a = AlphaOne;
        2:       a = AlphaW'($urandom_range(257, 511));
        default: a = AlphaW'($urandom_range(1, 255));
      endcase
      if ($urandom_range(0, 7) == 0) trip = $urandom_range(0, 1) ? '1 : '0;
      else trip = CurW'($urandom_range(200, 3800));
      case ($urandom_range(0, 5))
        0:       mins = 8'hFF;
        1:       mins = 8'd0;
        default: mins = 8'($urandom_range(1, 20));
      endcase
      case ($urandom_range(0, 6))
        0:       cons = 8'd0;
        1:       cons = 8'hFF;
        default: cons = 8'($urandom_range(1, 8));
      endcase
      configure(a, trip, mins, cons);
      for (int m = 0; m < NumMotors; m++)
        base[m] = clamp_current(int'(trip) + int'($urandom_range(0, 400)) - 200);
      repeat (120) begin
        if ($urandom_range(0, 99) < 15) begin
          s = random_sample();
        end else begin
          for (int m = 0; m < NumMotors; m++) begin
            base[m]      = clamp_current(int'(base[m]) + int'($urandom_range(0, 100)) - 50);
            s.current[m] = clamp_current(int'(base[m]) + int'($urandom_range(0, 128)) - 64);
          end
          s.drive     = ($urandom_range(0, 3) != 0);
          s.high_gear = ($urandom_range(0, 3) != 0);
        end
        send_sample(s);
      end
      drain();
    end
  endtask

  initial begin : rx_stall
    int seg_len;
    int stall_pct;
    int hold;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      seg_len = $urandom_range(10, 150);
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        2:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
      repeat (seg_len) begin
        @(posedge clk_i);
        if (hold_off_req > 0) begin
          hold         = hold_off_req;
          hold_off_req = 0;
          out_ready_i <= 1'b0;
          repeat (hold - 1) @(posedge clk_i);
        end else begin
          out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
        end
      end
    end
  end

  // a request seen valid and ready mid-cycle completes at the next rising edge
  always @(negedge clk_i) begin : check_status
    status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_fifo.size() == 0) begin
        $error("unexpected status: downshift %0d", downshift_o);
        n_errors++;
      end else begin
        want = status_fifo.pop_front();
        check_field("downshift", want.downshift, downshift_o);
        check_field("average_0", want.average[0], average_0_o);
        check_field("average_1", want.average[1], average_1_o);
        check_field("average_2", want.average[2], average_2_o);
        check_field("average_3", want.average[3], average_3_o);
        check_field("above_count_0", want.count[0], above_count_0_o);
        check_field("above_count_1", want.count[1], above_count_1_o);
        check_field("above_count_2", want.count[2], above_count_2_o);
        check_field("above_count_3", want.count[3], above_count_3_o);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles <= CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : main
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_ALPHA;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    current_0_i    = '0;
    current_1_i    = '0;
    current_2_i    = '0;
    current_3_i    = '0;
    drive_active_i = 1'b0;
    gear_is_high_i = 1'b0;
    alpha_q        = AlphaRst;
    trip_q         = CurW'(TripRst);
    min_steps_q    = MinStpRst;
    consec_q       = ConsecRst;
    steps_q        = '0;
    for (int m = 0; m < NumMotors; m++) begin
      ema_q[m] = '0;
      run_q[m] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_sample();
    test_alpha_extremes();
    test_thresholds();
    test_count_saturation();
    test_backpressure();
    test_random_phases();
    drain();
    repeat (TailWait) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
